>>> sv/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/kufef_pkg.sv
package kufef_pkg;

    // Fixed field widths of the stream items
    localparam int NODE_W   = 10;
    localparam int LEN_W    = 20;
    localparam int COUNT_W  = 10;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;

    // Input tdata layout: node_a, node_b, edge_length
    localparam int S_A_LSB    = 0;
    localparam int S_B_LSB    = S_A_LSB + NODE_W;
    localparam int S_LEN_LSB  = S_B_LSB + NODE_W;
    localparam int S_DATA_W   = 40;

    // Output tdata layout: tree_node_a, tree_node_b, largest_length,
    // any_tree_edge, tree_edge_count, zero pad
    localparam int M_A_LSB    = 0;
    localparam int M_B_LSB    = M_A_LSB + NODE_W;
    localparam int M_LEN_LSB  = M_B_LSB + NODE_W;
    localparam int M_ANY_BIT  = M_LEN_LSB + LEN_W;
    localparam int M_CNT_LSB  = M_ANY_BIT + 1;
    localparam int M_USED_W   = M_CNT_LSB + COUNT_W;
    localparam int M_DATA_W   = 56;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_FETCH,
        ST_ROOT_A,
        ST_COMP_A,
        ST_ROOT_B,
        ST_COMP_B,
        ST_LINK,
        ST_FINISH
    } state_t;

endpackage

>>> sv/kufef_forest_mem.sv
module kufef_forest_mem
#(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 11
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/kruskal_union_find_edge_filter.sv
// Kruskal edge filter: edges arrive on the slave stream in nondecreasing length
// order (the block does not sort) and each one yields exactly one result item. The
// block keeps a disjoint-set forest of parent links in a single-port-read,
// single-port-write memory of NODES entries; an edge whose endpoints have
// different roots is accepted and the root of node_a is linked under the root
// of node_b, with path compression on both walks. tuser on the input is
// start_req, which clears the forest and the totals before that edge is
// processed. One item at a time: an accepted edge steps through a root walk and
// a compression walk from node_a, then the same from node_b, then the link
// step, each walk stepping its pointer by the one memory read per cycle; the
// result item is then written to the output register. An edge with a node at
// or above NODES skips the walks and is not accepted. After reset, and after
// every start_req, a clearing sweep writes all NODES entries as roots, one per
// cycle, with the input not ready. A result not yet taken holds only the final
// step, so the next edge is taken and walked while the previous result waits
// in the output register.
module kruskal_union_find_edge_filter
    import kufef_pkg::*;
#(
    parameter int NODES       = 1024,
    parameter int LENGTH_BITS = 20
)
(
    input  logic                clk,
    input  logic                rst_n,
    // slave stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // node_a[9:0], node_b[19:10], edge_length[39:20]
    input  logic                s_tuser,   // start_req
    // master stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // tree_node_a[9:0], tree_node_b[19:10],
                                           // largest_length[39:20], any_tree_edge[40],
                                           // tree_edge_count[50:41], zero[55:51]
    output logic                m_tuser    // accepted
);

    localparam int ADDR_W  = $clog2(NODES);
    localparam int ENTRY_W = ADDR_W + 1;   // root flag on top, parent link below
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODES - 1);

    // sequencer state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   cur_reg, cur_next;         // walk pointer / sweep address
    logic [ADDR_W-1:0]   root_reg, root_next;       // root found by the current walk
    logic [ADDR_W-1:0]   root_a_reg, root_a_next;
    logic                pend_reg, pend_next;       // item waits for the sweep to end

    // item held during the walk
    logic [NODE_W-1:0]      a_reg, a_next;
    logic [NODE_W-1:0]      b_reg, b_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic                   acc_reg, acc_next;

    // running totals
    logic [LENGTH_BITS-1:0] max_reg, max_next;
    logic                   have_reg, have_next;
    logic [COUNT_W-1:0]     cnt_reg, cnt_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic                m_user_reg, m_user_next;

    // forest memory port
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0]  rd_data;

    logic                rd_root;
    logic [ADDR_W-1:0]   rd_link;
    logic [ADDR_W-1:0]   a_idx;
    logic [ADDR_W-1:0]   b_idx;
    logic                in_range;
    logic                out_free;
    logic                s_fire;

    kufef_forest_mem #(
        .DEPTH  (NODES),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_root  = rd_data[ADDR_W];
    assign rd_link  = rd_data[ADDR_W-1:0];
    assign a_idx    = ADDR_W'(a_reg);
    assign b_idx    = ADDR_W'(b_reg);
    assign in_range = (32'(a_reg) < NODES) && (32'(b_reg) < NODES);

    // The result slot is free when it is empty or drains this cycle
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cur_reg     <= '0;
            pend_reg    <= 1'b0;
            max_reg     <= '0;
            have_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cur_reg     <= cur_next;
            pend_reg    <= pend_next;
            max_reg     <= max_next;
            have_reg    <= have_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        root_reg   <= root_next;
        root_a_reg <= root_a_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        len_reg    <= len_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        root_next    = root_reg;
        root_a_next  = root_a_reg;
        pend_next    = pend_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        len_next     = len_reg;
        acc_next     = acc_reg;
        max_next     = max_reg;
        have_next    = have_reg;
        cnt_next     = cnt_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_valid_next = m_valid_reg && !m_tready;
        wr_en        = 1'b0;
        wr_addr      = cur_reg;
        wr_data      = {1'b0, root_reg};
        rd_addr      = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    a_next   = s_tdata[S_A_LSB +: NODE_W];
                    b_next   = s_tdata[S_B_LSB +: NODE_W];
                    len_next = LENGTH_BITS'(s_tdata[S_LEN_LSB +: LEN_W]);
                    if (s_tuser)
                    begin
                        // drop the old graph before this edge is looked at
                        max_next   = '0;
                        have_next  = 1'b0;
                        cnt_next   = '0;
                        cur_next   = '0;
                        pend_next  = 1'b1;
                        state_next = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end

            ST_CLEAR:
            begin
                // mark one entry a root with link zero per cycle
                wr_en   = 1'b1;
                wr_addr = cur_reg;
                wr_data = {1'b1, {ADDR_W{1'b0}}};
                if (cur_reg == LAST_ADDR)
                begin
                    pend_next  = 1'b0;
                    state_next = pend_reg ? ST_FETCH : ST_IDLE;
                end
                else
                begin
                    cur_next = cur_reg + ADDR_W'(1);
                end
            end

            ST_FETCH:
            begin
                acc_next = 1'b0;
                if (in_range)
                begin
                    cur_next   = a_idx;
                    rd_addr    = a_idx;
                    state_next = ST_ROOT_A;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_ROOT_A, ST_ROOT_B:
            begin
                // follow links until a root turns up, then restart from the endpoint
                if (rd_root)
                begin
                    root_next  = cur_reg;
                    cur_next   = (state_reg == ST_ROOT_A) ? a_idx : b_idx;
                    rd_addr    = cur_next;
                    state_next = (state_reg == ST_ROOT_A) ? ST_COMP_A : ST_COMP_B;
                end
                else
                begin
                    cur_next = rd_link;
                    rd_addr  = rd_link;
                end
            end

            ST_COMP_A, ST_COMP_B:
            begin
                // point each node on the path straight at the root
                if ((cur_reg == root_reg) || rd_root)
                begin
                    if (state_reg == ST_COMP_A)
                    begin
                        root_a_next = root_reg;
                        cur_next    = b_idx;
                        rd_addr     = b_idx;
                        state_next  = ST_ROOT_B;
                    end
                    else
                    begin
                        state_next = ST_LINK;
                    end
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cur_reg;
                    wr_data  = {1'b0, root_reg};
                    cur_next = rd_link;
                    rd_addr  = rd_link;
                end
            end

            ST_LINK:
            begin
                if (root_a_reg != root_reg)
                begin
                    // hang root of a under root of b, update the totals
                    wr_en     = 1'b1;
                    wr_addr   = root_a_reg;
                    wr_data   = {1'b0, root_reg};
                    acc_next  = 1'b1;
                    have_next = 1'b1;
                    if (!have_reg || (len_reg > max_reg))
                    begin
                        max_next = len_reg;
                    end
                    if (cnt_reg != COUNT_MAX)
                    begin
                        cnt_next = cnt_reg + COUNT_W'(1);
                    end
                end
                state_next = ST_FINISH;
            end

            ST_FINISH:
            begin
                // hold here while the previous result still waits
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_user_next  = acc_reg;
                    m_data_next  = '0;
                    m_data_next[M_A_LSB +: NODE_W]   = a_reg;
                    m_data_next[M_B_LSB +: NODE_W]   = b_reg;
                    m_data_next[M_LEN_LSB +: LEN_W]  = have_reg ? LEN_W'(max_reg) : '0;
                    m_data_next[M_ANY_BIT]           = have_reg;
                    m_data_next[M_CNT_LSB +: COUNT_W] = cnt_reg;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/kufef_checker.sv
module kufef_checker
    import kufef_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tuser
);

`include "assert_macros.svh"

    // A stalled result holds its payload
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // One item at a time: input closes right after an accept
    `ASSERT_CLK(a_one_item, s_tvalid && s_tready |=> !s_tready, "input ready right after accept")

    // An accepted edge means the tree is not empty
    `ASSERT_CLK(a_acc_any, m_tvalid && m_tuser |-> m_tdata[M_ANY_BIT] && (m_tdata[M_CNT_LSB +: COUNT_W] != '0), "accepted edge with empty tree")

    // Empty tree reports zero length and zero count
    `ASSERT_CLK(a_empty_zero, m_tvalid && !m_tdata[M_ANY_BIT] |-> (m_tdata[M_LEN_LSB +: LEN_W] == '0) && (m_tdata[M_CNT_LSB +: COUNT_W] == '0), "nonzero totals with empty tree")

endmodule

bind kruskal_union_find_edge_filter kufef_checker u_kufef_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

// Edge filter check: edges go in on the slave stream, one result item comes
// back per edge. A local disjoint-set forest predicts every result; the
// monitor compares each taken result with the oldest prediction.
module tb_top;
    import kufef_pkg::*;

    localparam int NODE_COUNT  = 1024;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int IDLE_PCT    = 19;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 60;    // items taken before the long hold-off
    localparam int CALM_FIRST  = 150;   // item window with no idling on either side
    localparam int CALM_LAST   = 260;
    localparam int DRAIN_WAIT  = 50;
    localparam int RANDOM_ITEMS = 400;
    localparam logic [LEN_W-1:0] LEN_TOP = {LEN_W{1'b1}};

    typedef struct packed {
        logic               start;
        logic [NODE_W-1:0]  a;
        logic [NODE_W-1:0]  b;
        logic [LEN_W-1:0]   len;
    } edge_item_t;

    typedef struct packed {
        logic               accepted;
        logic [NODE_W-1:0]  a;
        logic [NODE_W-1:0]  b;
        logic [LEN_W-1:0]   largest;
        logic               any;
        logic [COUNT_W-1:0] count;
    } tree_result_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;     // node_a, node_b, edge_length
    logic                s_tuser  = 1'b0;   // start_req
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;           // tree_node_a, tree_node_b, largest_length,
                                            // any_tree_edge, tree_edge_count, zero pad
    logic                m_tuser;           // accepted

    edge_item_t   pending_edges[$];
    tree_result_t expected_results[$];

    // Local copy of the forest and the running totals
    logic [NODE_W-1:0]  link_up[NODE_COUNT];
    logic               root_mark[NODE_COUNT];
    logic [LEN_W-1:0]   longest_kept;
    logic               tree_started;
    logic [COUNT_W-1:0] tree_edges;

    int  items_taken   = 0;
    int  results_taken = 0;
    int  fail_count    = 0;
    int  cycle_count   = 0;
    int  hold_left     = 0;
    logic hold_active  = 1'b0;
    logic hold_done    = 1'b0;

    kruskal_union_find_edge_filter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Forest predictor
    // ---------------------------------------------------------------
    function automatic void clear_forest();
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            link_up[i]   = '0;
            root_mark[i] = 1'b1;
        end
        longest_kept = '0;
        tree_started = 1'b0;
        tree_edges   = '0;
    endfunction

    // Walk up to the root, then point every node on the path straight at it.
    // Compression never changes set membership, but keep it anyway so the
    // local forest has the same shape as the block's.
    function automatic logic [NODE_W-1:0] find_root(logic [NODE_W-1:0] v);
        logic [NODE_W-1:0] r;
        logic [NODE_W-1:0] nx;
        int guard;
        r = v;
        guard = 0;
        while (!root_mark[r] && guard < NODE_COUNT)
        begin
            r = link_up[r];
            guard++;
        end
        guard = 0;
        while (v != r && !root_mark[v] && guard < NODE_COUNT)
        begin
            nx = link_up[v];
            link_up[v] = r;
            v = nx;
            guard++;
        end
        return r;
    endfunction

    // Node numbers are 10 bits wide and the forest has 1024 entries, so the
    // out-of-range rejection never applies here.
    function automatic tree_result_t judge_edge(edge_item_t e);
        tree_result_t res;
        logic [NODE_W-1:0] ra;
        logic [NODE_W-1:0] rb;
        if (e.start)
            clear_forest();
        res.accepted = 1'b0;
        ra = find_root(e.a);
        rb = find_root(e.b);
        if (ra != rb)
        begin
            link_up[ra]   = rb;
            root_mark[ra] = 1'b0;
            res.accepted  = 1'b1;
            if (!tree_started || e.len > longest_kept)
                longest_kept = e.len;
            tree_started = 1'b1;
            if (tree_edges != COUNT_MAX)
                tree_edges++;
        end
        res.a       = e.a;
        res.b       = e.b;
        res.largest = tree_started ? longest_kept : '0;
        res.any     = tree_started;
        res.count   = tree_edges;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------
    task automatic add_edge(logic start, int a, int b, int len);
        edge_item_t e;
        e.start = start;
        e.a     = a[NODE_W-1:0];
        e.b     = b[NODE_W-1:0];
        e.len   = len[LEN_W-1:0];
        pending_edges = {pending_edges, e};
    endtask

    // One small graph over a random pool of nodes with nondecreasing lengths.
    // Duplicates in the pool give self loops; extra edges close cycles.
    task automatic add_graph(logic with_start, inout int added);
        int pool[40];
        int k;
        int m;
        int len;
        int span;
        k = $urandom_range(2, 40);
        m = $urandom_range(k, 2 * k);
        for (int i = 0; i < k; i++)
            pool[i] = $urandom_range(0, NODE_COUNT - 1);
        len  = $urandom_range(0, int'(LEN_TOP));
        span = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 16) : $urandom_range(1, 40000);
        for (int i = 0; i < m; i++)
        begin
            add_edge(with_start && i == 0, pool[$urandom_range(0, k - 1)],
                     pool[$urandom_range(0, k - 1)], len);
            len = len + $urandom_range(0, span);
            if (len > int'(LEN_TOP))
                len = int'(LEN_TOP);
        end
        added += m;
    endtask

    task automatic build_stimulus();
        int added;
        int pick;
        int burst;
        // Directed part: starts from the reset forest with no start flag
        add_edge(1'b0, 0, 1023, 0);            // extremes, first edge, zero length
        add_edge(1'b0, 1023, 0, 5);            // same set, reversed: reject
        add_edge(1'b0, 512, 512, 7);           // self loop
        add_edge(1'b0, 'h2AA, 'h155, 'hAAAAA); // alternating bit patterns
        add_edge(1'b0, 'h155, 1, 'h55555);     // shorter length must not lower the max
        add_edge(1'b0, 1, 0, int'(LEN_TOP));   // merge two sets, longest length
        add_edge(1'b0, 'h2AA, 1023, int'(LEN_TOP));
        add_edge(1'b1, 1023, 0, 3);            // restart: forest and totals cleared
        add_edge(1'b0, 0, 1023, 3);
        add_edge(1'b1, 7, 7, 9);               // self loop right after restart
        add_edge(1'b0, 8, 9, 'h80000);
        add_edge(1'b0, 10, 11, 'h80000);       // build a chain to walk later
        add_edge(1'b0, 11, 12, 'h80001);
        add_edge(1'b0, 12, 13, 'h80001);
        add_edge(1'b0, 13, 14, 'h80002);
        add_edge(1'b0, 10, 20, 'h80003);       // deep walk from the chain bottom
        add_edge(1'b0, 11, 20, 'h80003);       // compressed path, same set
        add_edge(1'b0, 20, 8, 'h80004);
        add_edge(1'b0, 14, 9, 'h80005);

        // Random part: mostly well-formed graphs, some broken ones and noise
        added = 0;
        while (added < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                add_graph(1'b1, added);
            else if (pick < 85)
                add_graph(1'b0, added);
            else
            begin
                burst = $urandom_range(1, 5);
                for (int i = 0; i < burst; i++)
                    add_edge($urandom_range(0, 9) == 0, $urandom_range(0, NODE_COUNT - 1),
                             $urandom_range(0, NODE_COUNT - 1),
                             $urandom_range(0, int'(LEN_TOP)));
                added += burst;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: offer the next edge when the slot is free; predict on accept
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : edge_driver
        edge_item_t e;
        edge_item_t taken;
        logic calm;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                taken.start = s_tuser;
                taken.a     = s_tdata[S_A_LSB +: NODE_W];
                taken.b     = s_tdata[S_B_LSB +: NODE_W];
                taken.len   = s_tdata[S_LEN_LSB +: LEN_W];
                expected_results = {expected_results, judge_edge(taken)};
                items_taken++;
            end
            calm = items_taken >= CALM_FIRST && items_taken < CALM_LAST;
            // Hold the current item until it is taken, then advance or idle
            if (!s_tvalid || s_tready)
            begin
                if (pending_edges.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    e = pending_edges.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= e.start;
                    s_tdata  <= S_DATA_W'({e.len, e.b, e.a});
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, so the result register fills and the
    // block stops taking edges while the driver keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_active <= 1'b0;
            hold_done   <= 1'b0;
            hold_left   <= 0;
        end
        else if (!hold_done && !hold_active && items_taken >= HOLD_AFTER)
        begin
            hold_active <= 1'b1;
            hold_left   <= HOLD_CYCLES;
        end
        else if (hold_active)
        begin
            if (hold_left <= 1)
            begin
                hold_active <= 1'b0;
                hold_done   <= 1'b1;
            end
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare every taken result with the oldest prediction
    // ---------------------------------------------------------------
    task automatic check_field(string name, logic [LEN_W-1:0] want, logic [LEN_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: result %0d mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, results_taken, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        tree_result_t want;
        logic calm;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result with no edge pending, expected none, got tdata 0x%0h",
                             $realtime, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("accepted", LEN_W'(want.accepted), LEN_W'(m_tuser));
                    check_field("tree_node_a", LEN_W'(want.a),
                                LEN_W'(m_tdata[M_A_LSB +: NODE_W]));
                    check_field("tree_node_b", LEN_W'(want.b),
                                LEN_W'(m_tdata[M_B_LSB +: NODE_W]));
                    check_field("largest_length", want.largest, m_tdata[M_LEN_LSB +: LEN_W]);
                    check_field("any_tree_edge", LEN_W'(want.any), LEN_W'(m_tdata[M_ANY_BIT]));
                    check_field("tree_edge_count", LEN_W'(want.count),
                                LEN_W'(m_tdata[M_CNT_LSB +: COUNT_W]));
                    check_field("pad", '0, LEN_W'(m_tdata[M_DATA_W-1:M_USED_W]));
                end
                results_taken++;
            end
            calm = results_taken >= CALM_FIRST && results_taken < CALM_LAST;
            m_tready <= !hold_active && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clear_forest();
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        // Drain: every edge offered and taken, every result back; sample away
        // from the rising edge so the driver's updates have settled
        while (pending_edges.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
